// ===== rtl/bully_pkg.sv =====
// ----------------------------------------------------------------------------
// bully_pkg - shared types and constants for the bully leader election block
// Command, kind and status codes, sizes of the node table, and the command
// and status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package bully_pkg;

  localparam int unsigned MAX_NODES = 8;
  localparam int unsigned ID_WIDTH  = 16;
  localparam int unsigned IDX_W     = 4;   // node index field width
  localparam int unsigned SLOT_W    = $clog2(MAX_NODES);
  localparam int unsigned CNT_W     = 4;   // node_count register width
  localparam int unsigned LDID_W    = 16;  // load_identifier field width

  typedef enum logic [2:0] {
    CMD_LOAD     = 3'd0,
    CMD_CRASH    = 3'd1,
    CMD_ACTIVATE = 3'd2,
    CMD_SELECT   = 3'd3,
    CMD_ELECT    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_ELECT  = 2'd1,
    KIND_OK     = 2'd2,
    KIND_COORD  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_CRASHED   = 3'd1,
    ST_ACTIVE    = 3'd2,
    ST_INIT_DOWN = 3'd3,
    ST_BAD       = 3'd4
  } status_e;

  // Table read address source
  typedef enum logic [1:0] {
    RD_NODE  = 2'd0,
    RD_INIT  = 2'd1,
    RD_SCAN  = 2'd2,
    RD_COORD = 2'd3
  } rd_sel_e;

  // Which word the output register takes
  typedef enum logic [1:0] {
    EM_ELECT = 2'd0,
    EM_OK    = 2'd1,
    EM_FINAL = 2'd2
  } emit_sel_e;

  typedef struct packed {
    logic      latch_in;
    rd_sel_e   rd_sel;
    logic      load_wr;
    logic      live_clr;
    logic      live_set;
    logic      base_ld;
    logic      scan_clr;
    logic      scan_inc;
    logic      best_step;
    logic      coord_from_best;
    logic      coord_from_node;
    logic      fin_kind_ld;
    kind_e     fin_kind;
    logic      fin_status_ld;
    status_e   fin_status;
    logic      emit;
    emit_sel_e emit_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       node_ok;
    logic       init_ok;
    logic       rd_live;
    logic       node_is_coord;
    logic       act_take;
    logic       elect_hit;
    logic       ok_hit;
    logic       lead_hit;
    logic       scan_end;
    logic       out_free;
  } dp_sts_t;

endpackage

// ===== rtl/bully_ctrl.sv =====
// ----------------------------------------------------------------------------
// bully_ctrl - command sequencer
// Decodes the latched command and steps the datapath through the election
// scans, emitting one word at a time into the output register.
// ----------------------------------------------------------------------------
module bully_ctrl
  import bully_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DECODE   = 9'b000000010,
    S_ACT_CMP  = 9'b000000100,
    S_CHK_INIT = 9'b000001000,
    S_ELECT    = 9'b000010000,
    S_OKS      = 9'b000100000,
    S_LEADER   = 9'b001000000,
    S_SETCOORD = 9'b010000000,
    S_FINAL    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel     = RD_NODE;
    cmd_o.fin_kind   = KIND_STATUS;
    cmd_o.fin_status = ST_DONE;
    cmd_o.emit_sel   = EM_FINAL;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECODE;
        end
      end

      S_DECODE: begin
        cmd_o.rd_sel      = RD_NODE;
        cmd_o.fin_kind_ld = 1'b1;
        cmd_o.fin_kind    = KIND_STATUS;
        state_d           = S_FINAL;
        case (sts_i.cmd)
          CMD_LOAD: begin
            cmd_o.fin_status_ld = 1'b1;
            if (!sts_i.node_ok) begin
              cmd_o.fin_status = ST_BAD;
            end else begin
              cmd_o.load_wr    = 1'b1;
              cmd_o.fin_status = ST_DONE;
            end
          end
          CMD_CRASH: begin
            cmd_o.fin_status_ld = 1'b1;
            if (!sts_i.node_ok) begin
              cmd_o.fin_status = ST_BAD;
            end else if (!sts_i.rd_live) begin
              cmd_o.fin_status = ST_CRASHED;
            end else begin
              cmd_o.live_clr   = 1'b1;
              cmd_o.fin_status = ST_DONE;
              // losing the coordinator starts an election
              if (sts_i.node_is_coord) begin
                state_d = S_CHK_INIT;
              end
            end
          end
          CMD_ACTIVATE: begin
            cmd_o.fin_status_ld = 1'b1;
            if (!sts_i.node_ok) begin
              cmd_o.fin_status = ST_BAD;
            end else begin
              cmd_o.live_set   = 1'b1;
              cmd_o.base_ld    = 1'b1;
              cmd_o.fin_status = sts_i.rd_live ? ST_ACTIVE : ST_DONE;
              state_d          = S_ACT_CMP;
            end
          end
          CMD_SELECT: begin
            cmd_o.scan_clr = 1'b1;
            state_d        = S_LEADER;
          end
          CMD_ELECT: begin
            state_d = S_CHK_INIT;
          end
          default: begin
            cmd_o.fin_status_ld = 1'b1;
            cmd_o.fin_status    = ST_BAD;
          end
        endcase
      end

      S_ACT_CMP: begin
        cmd_o.rd_sel = RD_COORD;
        if (sts_i.act_take) begin
          cmd_o.coord_from_node = 1'b1;
          cmd_o.fin_kind_ld     = 1'b1;
          cmd_o.fin_kind        = KIND_COORD;
        end
        state_d = S_FINAL;
      end

      S_CHK_INIT: begin
        cmd_o.rd_sel = RD_INIT;
        if (!sts_i.init_ok) begin
          cmd_o.fin_kind_ld   = 1'b1;
          cmd_o.fin_status_ld = 1'b1;
          cmd_o.fin_status    = ST_BAD;
          state_d             = S_FINAL;
        end else if (!sts_i.rd_live) begin
          cmd_o.fin_kind_ld   = 1'b1;
          cmd_o.fin_status_ld = 1'b1;
          cmd_o.fin_status    = ST_INIT_DOWN;
          state_d             = S_FINAL;
        end else begin
          cmd_o.base_ld  = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = S_ELECT;
        end
      end

      S_ELECT: begin
        cmd_o.rd_sel   = RD_SCAN;
        cmd_o.emit_sel = EM_ELECT;
        // hold the scan while a message waits for the output register
        if (!(sts_i.elect_hit && !sts_i.out_free)) begin
          cmd_o.emit = sts_i.elect_hit;
          if (sts_i.scan_end) begin
            cmd_o.scan_clr = 1'b1;
            state_d        = S_OKS;
          end else begin
            cmd_o.scan_inc = 1'b1;
          end
        end
      end

      S_OKS: begin
        cmd_o.rd_sel   = RD_SCAN;
        cmd_o.emit_sel = EM_OK;
        if (!(sts_i.ok_hit && !sts_i.out_free)) begin
          cmd_o.emit = sts_i.ok_hit;
          if (sts_i.scan_end) begin
            cmd_o.scan_clr = 1'b1;
            state_d        = S_LEADER;
          end else begin
            cmd_o.scan_inc = 1'b1;
          end
        end
      end

      S_LEADER: begin
        cmd_o.rd_sel    = RD_SCAN;
        cmd_o.best_step = 1'b1;
        if (sts_i.scan_end) begin
          state_d = S_SETCOORD;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end

      S_SETCOORD: begin
        cmd_o.coord_from_best = 1'b1;
        cmd_o.fin_kind_ld     = 1'b1;
        cmd_o.fin_kind        = KIND_COORD;
        cmd_o.fin_status_ld   = 1'b1;
        cmd_o.fin_status      = ST_DONE;
        state_d               = S_FINAL;
      end

      S_FINAL: begin
        cmd_o.emit_sel = EM_FINAL;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // A word is only pushed when the output register can take it.
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("emit while output register full");

  // The scan never steps past the last node in use.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_inc |-> !sts_i.scan_end)
    else $error("scan stepped past last node");

  // Every accepted item reaches its final word before the next one enters.
  a_final_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL && cmd_o.emit) |=> in_ready_o)
    else $error("final word did not return to idle");

endmodule

// ===== rtl/bully_dp.sv =====
// ----------------------------------------------------------------------------
// bully_dp - node table and election datapath
// Holds the node table, the latched command, the scan counter, the running
// leader, the coordinator and the output register.
// ----------------------------------------------------------------------------
module bully_dp
  import bully_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CNT_W-1:0]     cfg_wdata_i,
  input  logic [2:0]           in_cmd_i,
  input  logic [IDX_W-1:0]     in_node_i,
  input  logic [IDX_W-1:0]     in_init_i,
  input  logic [LDID_W-1:0]    in_ld_id_i,
  input  logic                 in_ld_live_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_sts_t              sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           out_kind_o,
  output logic [IDX_W-1:0]     out_from_o,
  output logic [IDX_W-1:0]     out_to_o,
  output logic [2:0]           out_status_o,
  output logic [IDX_W-1:0]     out_coord_o,
  output logic                 out_last_o
);

  logic [CNT_W-1:0]    node_count_q;
  logic [MAX_NODES-1:0] live_q;
  logic [ID_WIDTH-1:0] id_q [MAX_NODES];
  logic [IDX_W-1:0]    coord_q;

  logic [2:0]          cmd_q;
  logic [IDX_W-1:0]    node_q, init_q;
  logic [ID_WIDTH-1:0] ld_id_q;
  logic                ld_live_q;

  logic [IDX_W-1:0]    scan_q;
  logic [ID_WIDTH-1:0] base_q;
  logic [IDX_W-1:0]    best_q;
  logic [ID_WIDTH-1:0] best_id_q;
  kind_e               fin_kind_q;
  status_e             fin_status_q;

  logic                out_valid_q;
  logic [1:0]          out_kind_q;
  logic [IDX_W-1:0]    out_from_q, out_to_q, out_coord_q;
  logic [2:0]          out_status_q;
  logic                out_last_q;

  logic [IDX_W-1:0]    used;
  logic [IDX_W-1:0]    rd_addr;
  logic [SLOT_W-1:0]   rd_slot, node_slot;
  logic [ID_WIDTH-1:0] rd_id;
  logic                rd_live;
  logic                out_free;

  // Clamp the node count to 1..MAX_NODES
  always_comb begin
    if (node_count_q == '0) begin
      used = IDX_W'(1);
    end else if (IDX_W'(node_count_q) > IDX_W'(MAX_NODES)) begin
      used = IDX_W'(MAX_NODES);
    end else begin
      used = IDX_W'(node_count_q);
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_NODE:  rd_addr = node_q;
      RD_INIT:  rd_addr = init_q;
      RD_SCAN:  rd_addr = scan_q;
      RD_COORD: rd_addr = coord_q;
      default:  rd_addr = node_q;
    endcase
  end

  assign rd_slot   = SLOT_W'(rd_addr - IDX_W'(1));
  assign node_slot = SLOT_W'(node_q - IDX_W'(1));
  assign rd_id     = id_q[rd_slot];
  assign rd_live   = live_q[rd_slot];
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.cmd           = cmd_q;
    sts_o.node_ok       = (node_q != '0) && (node_q <= used);
    sts_o.init_ok       = (init_q != '0) && (init_q <= used);
    sts_o.rd_live       = rd_live;
    sts_o.node_is_coord = (node_q == coord_q);
    sts_o.act_take      = (coord_q == '0) || (base_q > rd_id);
    sts_o.elect_hit     = (scan_q != init_q) && (rd_id > base_q);
    sts_o.ok_hit        = (scan_q != init_q) && (rd_id > base_q) && rd_live;
    sts_o.lead_hit      = rd_live && ((best_q == '0) || (rd_id > best_id_q));
    sts_o.scan_end      = (scan_q == used);
    sts_o.out_free      = out_free;
  end

  // Configuration and node table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CNT_W'(MAX_NODES);
      live_q       <= '0;
      for (int i = 0; i < MAX_NODES; i++) begin
        id_q[i] <= '0;
      end
      coord_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (cmd_i.load_wr) begin
        id_q[node_slot]   <= ld_id_q;
        live_q[node_slot] <= ld_live_q;
      end
      if (cmd_i.live_clr) begin
        live_q[node_slot] <= 1'b0;
      end
      if (cmd_i.live_set) begin
        live_q[node_slot] <= 1'b1;
      end
      if (cmd_i.coord_from_best) begin
        coord_q <= best_q;
      end
      if (cmd_i.coord_from_node) begin
        coord_q <= node_q;
      end
    end
  end

  // Latched command and scan working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      cmd_q     <= in_cmd_i;
      node_q    <= in_node_i;
      init_q    <= in_init_i;
      ld_id_q   <= ID_WIDTH'(in_ld_id_i);
      ld_live_q <= in_ld_live_i;
    end
    if (cmd_i.base_ld) begin
      base_q <= rd_id;
    end
    if (cmd_i.scan_clr) begin
      scan_q <= IDX_W'(1);
      best_q <= '0;
    end else begin
      if (cmd_i.scan_inc) begin
        scan_q <= scan_q + IDX_W'(1);
      end
      if (cmd_i.best_step && sts_o.lead_hit) begin
        best_q    <= scan_q;
        best_id_q <= rd_id;
      end
    end
    if (cmd_i.fin_kind_ld) begin
      fin_kind_q <= cmd_i.fin_kind;
    end
    if (cmd_i.fin_status_ld) begin
      fin_status_q <= cmd_i.fin_status;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_coord_q <= coord_q;
      case (cmd_i.emit_sel)
        EM_ELECT: begin
          out_kind_q   <= KIND_ELECT;
          out_from_q   <= init_q;
          out_to_q     <= scan_q;
          out_status_q <= ST_DONE;
          out_last_q   <= 1'b0;
        end
        EM_OK: begin
          out_kind_q   <= KIND_OK;
          out_from_q   <= scan_q;
          out_to_q     <= init_q;
          out_status_q <= ST_DONE;
          out_last_q   <= 1'b0;
        end
        default: begin
          out_kind_q   <= fin_kind_q;
          out_from_q   <= '0;
          out_to_q     <= '0;
          out_status_q <= fin_status_q;
          out_last_q   <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_from_o   = out_from_q;
  assign out_to_o     = out_to_q;
  assign out_status_o = out_status_q;
  assign out_coord_o  = out_coord_q;
  assign out_last_o   = out_last_q;

  // The coordinator always names a table slot or nobody.
  a_coord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coord_q <= IDX_W'(MAX_NODES))
    else $error("coordinator outside node table");

endmodule

// ===== rtl/bully_leader_election_top.sv =====
// ----------------------------------------------------------------------------
// bully_leader_election_top - bully leader election over a node table
// Keeps up to eight nodes (live flag, identifier) and runs elections on
// command, reporting messages, replies and the elected coordinator.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis channel, one word per command. Each command
//   yields one or more result words on m_axis; tlast marks the final word of
//   a command, tuser carries the word kind (status, election message, OK
//   reply, coordinator announcement).
//   cfg_we_i/cfg_wdata_i write node_count; write it only while no command is
//   in flight.
// Timing:
//   The single word of load, plain crash, unknown codes, refused elections,
//   activate and select is registered once the command has been decoded,
//   after the coordinator compare for activate and the leader search for select.
//   An election over n nodes walks the table three times (messages, replies,
//   leader search), one node per cycle through the single table read port
//   while the output register can take each message; the scan holds on a
//   message while it waits. Its final word follows the leader search. The next
//   command is accepted in the cycle after the final word is registered.
// Reset:
//   Clears all live flags and identifiers, clears the coordinator to none and
//   sets node_count to eight. No clearing pass is needed.
// Back-pressure:
//   While m_axis_tready is low, the output register holds its word and the
//   scan pauses on the next word to send; nothing is dropped.
// ----------------------------------------------------------------------------
module bully_leader_election_top
  import bully_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: node_count
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  // command words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] cmd, [6:3] node_index, [10:7] initiator_index,
  // [26:11] load_identifier, [27] load_live, [31:28] zero
  input  logic [31:0] s_axis_tdata,
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] from_index, [7:4] to_index, [10:8] status,
  // [14:11] coordinator_index, [15] zero
  output logic [15:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  ctrl_cmd_t        cmd;
  dp_sts_t          sts;
  logic [IDX_W-1:0] out_from, out_to, out_coord;
  logic [2:0]       out_status;

  bully_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bully_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_cmd_i     (s_axis_tdata[2:0]),
    .in_node_i    (s_axis_tdata[6:3]),
    .in_init_i    (s_axis_tdata[10:7]),
    .in_ld_id_i   (s_axis_tdata[26:11]),
    .in_ld_live_i (s_axis_tdata[27]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (m_axis_tuser),
    .out_from_o   (out_from),
    .out_to_o     (out_to),
    .out_status_o (out_status),
    .out_coord_o  (out_coord),
    .out_last_o   (m_axis_tlast)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata = {1'b0, out_coord, out_status, out_to, out_from};

endmodule
